// ----- hdl/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared constants, field widths and controller/datapath command types for the
// cubic-Bezier easing core.
// ----------------------------------------------------------------------------
`default_nettype none

package cbe_pkg;

  localparam int unsigned NewtonStepsDef  = 4;
  localparam int unsigned FractionBitsDef = 16;

  localparam int unsigned ProgW    = 17;
  localparam int unsigned CtrlXW   = 17;
  localparam int unsigned CtrlYW   = 18;
  localparam int unsigned OutW     = 18;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CTRL1_X = 2'd0,
    CFG_CTRL1_Y = 2'd1,
    CFG_CTRL2_X = 2'd2,
    CFG_CTRL2_Y = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_WB,
    OP_SADD,
    OP_DIV,
    OP_TUPD,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    OPA_A3,
    OPA_B2,
    OPA_COEF_A,
    OPA_ACC
  } opa_sel_t;

  typedef enum logic [2:0] {
    ADD_NONE,
    ADD_B,
    ADD_C,
    ADD_ACC,
    ADD_NEG_X
  } add_sel_t;

  typedef struct packed {
    dp_op_t   op;
    opa_sel_t opa;
    add_sel_t add;
    logic     dst_s;
    logic     coef_y;
  } dp_cmd_t;

  typedef struct packed {
    logic linear;
    logic slope_zero;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/cbe_div.sv -----
// ----------------------------------------------------------------------------
// cbe_div
// Radix-2 restoring fixed-point divider, one quotient bit per cycle, with
// saturation when the integer part of the quotient reaches 64.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_div #(
  parameter int unsigned W = 23,
  parameter int unsigned F = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [W-1:0] num,
  input  wire logic signed [W-1:0] den,
  output logic                     done,
  output logic signed [W-1:0]      quo
);

  localparam int unsigned MW = W - 1;
  localparam int unsigned QW = F + 6;
  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [MW-1:0] r_r;
  logic [QW-1:0] sh_r;
  logic [QW-1:0] q_r;
  logic [MW-1:0] md_r;
  logic          neg_r;

  logic [MW-1:0] mn;
  logic [MW-1:0] md;
  logic          ovf;
  logic [MW:0]   rs;
  logic          ge;
  logic [MW-1:0] rn;

  assign mn  = num[W-1] ? MW'(-num) : num[MW-1:0];
  assign md  = den[W-1] ? MW'(-den) : den[MW-1:0];
  assign ovf = {6'b0, mn} >= {md, 6'b0};
  assign rs  = {r_r, sh_r[QW-1]};
  assign ge  = rs >= {1'b0, md_r};
  assign rn  = ge ? MW'(rs - {1'b0, md_r}) : rs[MW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r <= num[W-1] ^ den[W-1];
        md_r  <= md;
        if (md == '0) begin
          q_r    <= '0;
          done_r <= 1'b1;
        end else if (ovf) begin
          q_r    <= '1;
          done_r <= 1'b1;
        end else begin
          r_r    <= MW'(mn >> 6);
          sh_r   <= {mn[5:0], {F{1'b0}}};
          q_r    <= '0;
          cnt_r  <= CW'(QW);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        r_r   <= rn;
        sh_r  <= sh_r << 1;
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -W'(q_r) : W'(q_r);

endmodule

`default_nettype wire

// ----- hdl/cbe_dpath.sv -----
// ----------------------------------------------------------------------------
// cbe_dpath
// Datapath: configuration registers, curve coefficients, shared multiply and
// accumulate unit, divider, Newton update and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_dpath import cbe_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CfgIdxW-1:0]         cfg_index,
  input  wire logic [CfgDataW-1:0]        cfg_data,
  input  wire logic [ProgW-1:0]           progress,
  input  wire dp_cmd_t                    cmd,
  output dp_stat_t                        stat,
  output logic signed [OutW-1:0]          eased_value
);

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned W  = F + 7;
  localparam int unsigned MW = W - 1;
  localparam int unsigned TW = F + 2;
  localparam int unsigned SW = ((W > 18) ? W : 18) + 4;
  localparam int unsigned PW = MW + TW;
  localparam int unsigned HW = PW - F;

  localparam logic signed [SW-1:0] VlimS = SW'((64'sd1 <<< (F + 6)) - 64'sd1);
  localparam logic signed [SW-1:0] TmaxS = SW'((64'sd2 <<< F) - 64'sd1);
  localparam logic signed [SW-1:0] TminS = SW'(-(64'sd2 <<< F));
  localparam logic signed [SW-1:0] OneS  = SW'(64'sd1 <<< F);
  localparam logic signed [TW-1:0] OneT  = TW'(64'sd1 <<< F);
  localparam logic signed [TW-1:0] SnapT = TW'(((64'sd997 <<< F) + 64'sd999) / 64'sd1000);
  localparam logic [63:0]          One64 = 64'd1 << F;

  function automatic logic signed [W-1:0] sat_v(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > VlimS) begin
      r = VlimS;
    end else if (v < -VlimS) begin
      r = -VlimS;
    end else begin
      r = v;
    end
    return W'(r);
  endfunction

  function automatic logic signed [TW-1:0] sat_tf(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > TmaxS) begin
      r = TmaxS;
    end else if (v < TminS) begin
      r = TminS;
    end else begin
      r = v;
    end
    return TW'(r);
  endfunction

  logic [CtrlXW-1:0]        c1x_r;
  logic signed [CtrlYW-1:0] c1y_r;
  logic [CtrlXW-1:0]        c2x_r;
  logic signed [CtrlYW-1:0] c2y_r;

  logic [ProgW-1:0]         x_r;
  logic signed [TW-1:0]     t_r;
  logic signed [W-1:0]      acc_r;
  logic signed [W-1:0]      s_r;
  logic [PW-1:0]            prod_r;
  logic                     neg_r;
  logic signed [OutW-1:0]   eased_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1x_r <= '0;
      c1y_r <= '0;
      c2x_r <= CtrlXW'(65536);
      c2y_r <= CtrlYW'(65536);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CTRL1_X: c1x_r <= cfg_data[CtrlXW-1:0];
        CFG_CTRL1_Y: c1y_r <= cfg_data;
        CFG_CTRL2_X: c2x_r <= cfg_data[CtrlXW-1:0];
        CFG_CTRL2_Y: c2y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [SW-1:0] p1x, p2x, p1y, p2y;
  logic signed [W-1:0]  ax, bx, cx, ay, by, cy;
  logic signed [W-1:0]  ca, cb, cc;
  logic                 linear;

  assign p1x = SW'({1'b0, c1x_r});
  assign p2x = SW'({1'b0, c2x_r});
  assign p1y = SW'(c1y_r);
  assign p2y = SW'(c2y_r);

  assign ax = sat_v(SW'(OneS - 3 * p2x + 3 * p1x));
  assign bx = sat_v(SW'(3 * p2x - 6 * p1x));
  assign cx = sat_v(SW'(3 * p1x));
  assign ay = sat_v(SW'(OneS - 3 * p2y + 3 * p1y));
  assign by = sat_v(SW'(3 * p2y - 6 * p1y));
  assign cy = sat_v(SW'(3 * p1y));

  assign ca = cmd.coef_y ? ay : ax;
  assign cb = cmd.coef_y ? by : bx;
  assign cc = cmd.coef_y ? cy : cx;

  assign linear = (c1x_r == '0) && (c1y_r == '0) &&
                  (64'(c2x_r) == One64) && (64'(c2y_r) == One64);

  // multiply stage
  logic signed [W-1:0] opa_v;
  logic [MW-1:0]       mag_a;
  logic [TW-1:0]       mag_t;

  always_comb begin
    case (cmd.opa)
      OPA_A3:     opa_v = sat_v(SW'(3 * SW'(ca)));
      OPA_B2:     opa_v = sat_v(SW'(2 * SW'(cb)));
      OPA_COEF_A: opa_v = ca;
      OPA_ACC:    opa_v = acc_r;
      default:    opa_v = acc_r;
    endcase
  end

  assign mag_a = opa_v[W-1] ? MW'(-opa_v) : opa_v[MW-1:0];
  assign mag_t = t_r[TW-1] ? TW'(-t_r) : TW'(t_r);

  // write-back stage
  logic [HW-1:0]        m_hi;
  logic [MW-1:0]        m_cl;
  logic signed [SW-1:0] prod_s;
  logic signed [SW-1:0] addend;
  logic signed [W-1:0]  wb_v;

  assign m_hi   = prod_r[PW-1:F];
  assign m_cl   = (|m_hi[HW-1:MW]) ? '1 : m_hi[MW-1:0];
  assign prod_s = neg_r ? -SW'(m_cl) : SW'(m_cl);

  always_comb begin
    case (cmd.add)
      ADD_NONE:  addend = '0;
      ADD_B:     addend = SW'(cb);
      ADD_C:     addend = SW'(cc);
      ADD_ACC:   addend = SW'(acc_r);
      ADD_NEG_X: addend = -SW'(x_r);
      default:   addend = '0;
    endcase
  end

  assign wb_v = sat_v(SW'(prod_s + addend));

  // divider
  logic signed [W-1:0] quo;
  logic                div_done;

  cbe_div #(
    .W (W),
    .F (F)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV),
    .num   (acc_r),
    .den   (s_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign stat = '{linear: linear, slope_zero: (s_r == '0), div_done: div_done};

  // result
  logic signed [TW-1:0] yt;
  logic signed [TW-1:0] ys;

  assign yt = sat_tf(SW'(acc_r));
  assign ys = (yt >= SnapT) ? OneT : yt;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r <= progress;
        t_r <= sat_tf(SW'(progress));
      end
      OP_MUL: begin
        prod_r <= PW'(mag_a) * PW'(mag_t);
        neg_r  <= opa_v[W-1] ^ t_r[TW-1];
      end
      OP_WB: begin
        if (cmd.dst_s) begin
          s_r <= wb_v;
        end else begin
          acc_r <= wb_v;
        end
      end
      OP_SADD: s_r <= sat_v(SW'(SW'(s_r) + SW'(cc)));
      OP_TUPD: t_r <= sat_tf(SW'(SW'(t_r) - SW'(quo)));
      OP_OUT:  eased_r <= linear ? OutW'(x_r) : OutW'(ys);
      default: ;
    endcase
  end

  assign eased_value = eased_r;

endmodule

`default_nettype wire

// ----- hdl/cbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbe_ctrl
// Sequencer: steps the datapath through slope, curve, divide and Newton
// update for each Newton step of an item, then through the final y evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_ctrl import cbe_pkg::*; #(
  parameter int unsigned NEWTON_STEPS = NewtonStepsDef
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam int unsigned IterW = $clog2(NEWTON_STEPS + 1);
  localparam logic [IterW-1:0] IterLast = IterW'(NEWTON_STEPS - 1);

  localparam logic [3:0] RowSlopeA = 4'd0;
  localparam logic [3:0] RowSlopeB = 4'd1;
  localparam logic [3:0] RowSlopeC = 4'd2;
  localparam logic [3:0] RowErrA   = 4'd3;
  localparam logic [3:0] RowErrB   = 4'd4;
  localparam logic [3:0] RowErrC   = 4'd5;
  localparam logic [3:0] RowYA     = 4'd6;
  localparam logic [3:0] RowYB     = 4'd7;
  localparam logic [3:0] RowYC     = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_SADD,
    ST_CHK,
    ST_DIV,
    ST_DIVW,
    ST_TUPD,
    ST_FIN
  } state_t;

  state_t           state_r;
  logic [3:0]       row_r;
  logic [IterW-1:0] iter_r;
  logic             out_valid_r;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '{op: OP_NONE, opa: OPA_ACC, add: ADD_NONE, dst_s: 1'b0, coef_y: 1'b0};
    case (row_r)
      RowSlopeA: cmd.opa = OPA_A3;
      RowSlopeB: cmd.opa = OPA_ACC;
      RowSlopeC: begin
        cmd.opa   = OPA_B2;
        cmd.add   = ADD_ACC;
        cmd.dst_s = 1'b1;
      end
      RowErrA: begin
        cmd.opa = OPA_COEF_A;
        cmd.add = ADD_B;
      end
      RowErrB: cmd.add = ADD_C;
      RowErrC: cmd.add = ADD_NEG_X;
      RowYA: begin
        cmd.opa    = OPA_COEF_A;
        cmd.add    = ADD_B;
        cmd.coef_y = 1'b1;
      end
      RowYB: begin
        cmd.add    = ADD_C;
        cmd.coef_y = 1'b1;
      end
      RowYC: cmd.coef_y = 1'b1;
      default: ;
    endcase
    case (state_r)
      ST_IDLE: if (in_valid) cmd.op = OP_LOAD;
      ST_MUL:  cmd.op = OP_MUL;
      ST_WB:   cmd.op = OP_WB;
      ST_SADD: cmd.op = OP_SADD;
      ST_DIV:  cmd.op = OP_DIV;
      ST_TUPD: cmd.op = OP_TUPD;
      ST_FIN:  if (out_free) cmd.op = OP_OUT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= RowSlopeA;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ((state_r == ST_FIN) && out_free) || (out_valid_r && !out_ready);
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            iter_r <= '0;
            row_r  <= RowSlopeA;
            state_r <= stat.linear ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: state_r <= ST_WB;
        ST_WB: begin
          case (row_r)
            RowSlopeC: state_r <= ST_SADD;
            RowErrC:   state_r <= ST_DIV;
            RowYC:     state_r <= ST_FIN;
            default: begin
              row_r   <= row_r + 4'd1;
              state_r <= ST_MUL;
            end
          endcase
        end
        ST_SADD: state_r <= ST_CHK;
        ST_CHK: begin
          row_r   <= stat.slope_zero ? RowYA : RowErrA;
          state_r <= ST_MUL;
        end
        ST_DIV: state_r <= ST_DIVW;
        ST_DIVW: if (stat.div_done) state_r <= ST_TUPD;
        ST_TUPD: begin
          if (iter_r == IterLast) begin
            row_r <= RowYA;
          end else begin
            iter_r <= iter_r + 1'b1;
            row_r  <= RowSlopeA;
          end
          state_r <= ST_MUL;
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_divw_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVW |-> $past(state_r) == ST_DIV || $past(state_r) == ST_DIVW)
    else $error("divider wait entered without a divide start");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside the finish state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("transfer accepted but sequencer stayed idle");

  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= IterLast)
    else $error("Newton step count out of range");

endmodule

`default_nettype wire

// ----- hdl/cubic_bezier_easing_core.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_easing_core
// Flow: one item at a time; shorter when the slope reaches zero or a quotient
//   saturates, and shortest for the linear points, which skip the Newton steps.
//   Each Newton step runs the slope and curve evaluation, the divider and the
//   update of t.
//   A result still held on the output stalls the next one in the finish state.
// Reset: synchronous active-low rst_n; control points return to (0,0),(1,1).
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_easing_core import cbe_pkg::*; #(
  parameter int unsigned NEWTON_STEPS  = NewtonStepsDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ProgW-1:0]     in_progress_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [OutW-1:0]    out_eased_value,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cbe_ctrl #(
    .NEWTON_STEPS (NEWTON_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cbe_dpath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .progress    (in_progress_in),
    .cmd         (cmd),
    .stat        (stat),
    .eased_value (out_eased_value)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for cubic_bezier_easing_core. A queue-fed driver offers progress
// values in random bursts, a monitor checks each eased value against a
// fixed-point Newton solver kept here, across several control point settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cbe_pkg::*;

  localparam longint Q1   = 64'sd65536;
  localparam longint VMAX = (64'sd64 <<< 16) - 1;
  localparam longint TMAX = (64'sd2 <<< 16) - 1;
  localparam longint TMIN = -(64'sd2 <<< 16);
  localparam longint SNAP = ((64'sd997 <<< 16) + 999) / 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ProgW-1:0] in_progress_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OutW-1:0] out_eased_value;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_CTRL1_X;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_taken = 1'b0;

  cubic_bezier_easing_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  longint p1x, p1y, p2x, p2y;
  logic [ProgW-1:0] progress_q[$];
  logic [OutW-1:0] eased_q[$];
  int errors = 0;
  int hold_off = 0;
  int burst_left = 0, gap_left = 0;

  function automatic longint clampv(longint v);
    if (v > VMAX) return VMAX;
    if (v < -VMAX) return -VMAX;
    return v;
  endfunction

  function automatic longint clampt(longint v);
    if (v > TMAX) return TMAX;
    if (v < TMIN) return TMIN;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint ma, mb, m;
    bit neg;
    a = clampv(a);
    b = clampv(b);
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m = ma * (mb >>> 16) + (ma >>> 16) * (mb & 16'hffff)
        + (((ma & 16'hffff) * (mb & 16'hffff)) >>> 16);
    if (m > VMAX) m = VMAX;
    return neg ? -m : m;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint mn, md, q, r;
    bit neg;
    n = clampv(n);
    d = clampv(d);
    neg = (n < 0) != (d < 0);
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    if (md == 0) return 0;
    q = mn / md;
    r = mn % md;
    if (q >= 64) return neg ? -VMAX : VMAX;
    for (int i = 0; i < 16; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= md) begin
        r -= md;
        q |= 1;
      end
    end
    if (q > VMAX) q = VMAX;
    return neg ? -q : q;
  endfunction

  function automatic longint poly(longint t, longint a, longint b, longint c);
    longint v;
    v = clampv(fmul(a, t) + b);
    v = clampv(fmul(v, t) + c);
    return fmul(v, t);
  endfunction

  function automatic logic [OutW-1:0] ease(logic [ProgW-1:0] xin);
    longint x, t, y, ax, bx, cx, ay, by, cy, s, e;
    x = xin;
    if (p1x == 0 && p1y == 0 && p2x == Q1 && p2y == Q1) return OutW'(x);
    ax = clampv(Q1 - 3 * p2x + 3 * p1x);
    bx = clampv(3 * p2x - 6 * p1x);
    cx = clampv(3 * p1x);
    ay = clampv(Q1 - 3 * p2y + 3 * p1y);
    by = clampv(3 * p2y - 6 * p1y);
    cy = clampv(3 * p1y);
    t = clampt(x);
    for (int i = 0; i < NewtonStepsDef; i++) begin
      s = clampv(fmul(fmul(3 * ax, t), t) + fmul(2 * bx, t));
      s = clampv(s + cx);
      if (s == 0) break;
      e = clampv(poly(t, ax, bx, cx) - x);
      t = clampt(t - fdiv(e, s));
    end
    y = clampt(poly(t, ay, by, cy));
    if (y >= SNAP) y = Q1;
    return OutW'(y);
  endfunction

  task automatic write_reg(cfg_idx_t idx, longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDataW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CTRL1_X: p1x = val & 64'h1ffff;
      CFG_CTRL1_Y: p1y = longint'($signed(18'(val)));
      CFG_CTRL2_X: p2x = val & 64'h1ffff;
      default: p2y = longint'($signed(18'(val)));
    endcase
  endtask

  task automatic set_curve(longint ax1, longint ay1, longint ax2, longint ay2);
    write_reg(CFG_CTRL1_X, ax1);
    write_reg(CFG_CTRL1_Y, ay1);
    write_reg(CFG_CTRL2_X, ax2);
    write_reg(CFG_CTRL2_Y, ay2);
  endtask

  task automatic queue_progress(logic [ProgW-1:0] x);
    progress_q.push_back(x);
    eased_q.push_back(ease(x));
  endtask

  task automatic drain;
    while (progress_q.size() != 0 || eased_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(progress_q.pop_front());
      end
      if (in_valid && !in_taken) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (progress_q.size() > 0) begin
        in_valid <= 1'b1;
        in_progress_in <= progress_q[0];
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 120);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (eased_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %0d", $time,
                 out_eased_value);
        errors++;
      end else begin
        if (out_eased_value !== eased_q[0]) begin
          $display("%0t: eased_value mismatch, expected %0d actual %0d", $time,
                   $signed(eased_q[0]), out_eased_value);
          errors++;
        end
        void'(eased_q.pop_front());
      end
    end
  end

  initial begin
    #400ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    longint cx1, cx2;
    p1x = 0; p1y = 0; p2x = Q1; p2y = Q1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // linear pass-through at reset values
    queue_progress(0);
    queue_progress(17'h10000);
    queue_progress(17'h1ffff);
    queue_progress(17'h08000);
    drain();
    set_curve(16384, 6554, 45875, 65536);
    queue_progress(0);
    queue_progress(65536);
    queue_progress(17'h1ffff);
    queue_progress(32768);
    queue_progress(65000);
    queue_progress(65400);
    drain();
    // zero slope at t = 0, extremes of control points
    set_curve(0, -131072, 65536, 131071);
    queue_progress(0);
    queue_progress(1);
    queue_progress(65536);
    queue_progress(17'h1ffff);
    drain();
    set_curve(17'h1ffff, 131071, 17'h1ffff, -131072);
    queue_progress(0);
    queue_progress(40000);
    queue_progress(17'h1ffff);
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_off = 3000;
    for (int i = 0; i < 20; i++) queue_progress($urandom_range(0, 65536));
    drain();
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 6) set_curve(0, 0, 65536, 65536);
      else if ($urandom_range(0, 3) == 0)
        set_curve($urandom_range(0, 17'h1ffff), $urandom_range(0, 18'h3ffff),
                  $urandom_range(0, 17'h1ffff), $urandom_range(0, 18'h3ffff));
      else begin
        cx1 = $urandom_range(0, 65536);
        cx2 = $urandom_range(0, 65536);
        set_curve(cx1, longint'($urandom_range(0, 98304)) - 16384, cx2,
                  longint'($urandom_range(0, 98304)) - 16384);
      end
      for (int i = 0; i < 200; i++) begin
        case ($urandom_range(0, 9))
          0: queue_progress($urandom_range(0, 17'h1ffff));
          1: queue_progress($urandom_range(0, 1) ? 65536 : 0);
          default: queue_progress($urandom_range(0, 65536));
        endcase
      end
      drain();
    end
    if (errors == 0 && eased_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/cbe_pkg.sv
hdl/cbe_div.sv
hdl/cbe_dpath.sv
hdl/cbe_ctrl.sv
hdl/cubic_bezier_easing_core.sv
tb/tb_top.sv
